// ===== design/rgb2yuv_pkg.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_pkg
// Shared types and constants of the RGB to YCbCr 4:2:0 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgb2yuv_pkg;

  // configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

  // size limits
  localparam int MAX_WIDTH_DEFAULT  = 2048;
  localparam int MAX_HEIGHT_DEFAULT = 2048;
  localparam int SIZE_W             = 14;

  // component and sum widths
  localparam int COMP_W  = 8;
  localparam int PAIR_W  = 9;
  localparam int BLOCK_W = 10;
  localparam int CHROMA_SUM_W = 20;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // conversion constants
  localparam int LUMA_COEF_R   = 66;
  localparam int LUMA_COEF_G   = 129;
  localparam int LUMA_COEF_B   = 25;
  localparam int LUMA_SHIFT    = 8;
  localparam int LUMA_OFFSET   = 16;
  localparam int CB_COEF_R     = 38;
  localparam int CB_COEF_G     = 74;
  localparam int CB_COEF_B     = 112;
  localparam int CR_COEF_R     = 112;
  localparam int CR_COEF_G     = 94;
  localparam int CR_COEF_B     = 18;
  localparam int CHROMA_SHIFT  = 10;
  localparam int CHROMA_OFFSET = 128;

  // horizontal pair sums kept in the line buffer
  typedef struct packed {
    logic [PAIR_W-1:0] red;
    logic [PAIR_W-1:0] green;
    logic [PAIR_W-1:0] blue;
  } pair_sum_t;

  // word passed from front to back
  typedef struct packed {
    logic [COMP_W-1:0]  red;
    logic [COMP_W-1:0]  green;
    logic [COMP_W-1:0]  blue;
    logic               chroma;
    logic               frame_end;
    logic [BLOCK_W-1:0] sum_red;
    logic [BLOCK_W-1:0] sum_green;
    logic [BLOCK_W-1:0] sum_blue;
  } pix_word_t;

endpackage

`default_nettype wire

// ===== design/rgb2yuv_ram.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2yuv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/rgb2yuv_front.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_front
// Accepts pixels, tracks row and column, builds pair sums, runs the line
// buffer and hands each pixel with its 2x2 block sums to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2yuv_front #(
  parameter int MAX_WIDTH  = rgb2yuv_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = rgb2yuv_pkg::MAX_HEIGHT_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  input  wire logic [rgb2yuv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rgb2yuv_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [rgb2yuv_pkg::COMP_W-1:0]      red,
  input  wire logic [rgb2yuv_pkg::COMP_W-1:0]      green,
  input  wire logic [rgb2yuv_pkg::COMP_W-1:0]      blue,
  output logic                                     push,
  output rgb2yuv_pkg::pix_word_t                   push_word,
  input  wire logic                                queue_full
);

  import rgb2yuv_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH / 2;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CFG_DATA_W-1:0] frame_width;
  logic [CFG_DATA_W-1:0] frame_height;
  logic [CW-1:0]         column_count;
  logic [RW-1:0]         row_count;
  pair_sum_t             pair_sums;
  pair_sum_t             pair_next;

  logic [SIZE_W-1:0] width_even;
  logic [SIZE_W-1:0] height_even;
  logic [SIZE_W-1:0] width_eff;
  logic [SIZE_W-1:0] height_eff;
  logic              col_last;
  logic              row_last;
  logic              accept;
  logic              ready;
  logic [AW-1:0]     slot;
  logic              store_we;
  logic              store_re;
  pair_sum_t         above;

  logic              s1_valid;
  logic [COMP_W-1:0] s1_red;
  logic [COMP_W-1:0] s1_green;
  logic [COMP_W-1:0] s1_blue;
  logic              s1_chroma;
  logic              s1_frame_end;
  pair_sum_t         s1_pair;

  // configuration registers, always ready
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective frame size: even, clamped to 2..max
  always_comb begin
    width_even  = SIZE_W'({frame_width[CFG_DATA_W-1:1], 1'b0});
    height_even = SIZE_W'({frame_height[CFG_DATA_W-1:1], 1'b0});
    if (width_even < SIZE_W'(2)) begin
      width_eff = SIZE_W'(2);
    end else if (width_even > SIZE_W'(MAX_WIDTH)) begin
      width_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      width_eff = width_even;
    end
    if (height_even < SIZE_W'(2)) begin
      height_eff = SIZE_W'(2);
    end else if (height_even > SIZE_W'(MAX_HEIGHT)) begin
      height_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      height_eff = height_even;
    end
  end

  assign col_last = SIZE_W'(column_count) >= (width_eff - SIZE_W'(1));
  assign row_last = SIZE_W'(row_count) >= (height_eff - SIZE_W'(1));

  // handshake: the stage register frees up when it pushes
  assign push     = s1_valid && !queue_full;
  assign ready    = !s1_valid || !queue_full;
  assign in_stall = !ready;
  assign accept   = in_valid && ready;

  // pair sum including this pixel
  assign pair_next.red   = pair_sums.red   + PAIR_W'(red);
  assign pair_next.green = pair_sums.green + PAIR_W'(green);
  assign pair_next.blue  = pair_sums.blue  + PAIR_W'(blue);

  // position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (col_last) begin
        column_count <= '0;
        if (row_last) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + RW'(1);
        end
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // horizontal pair register
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!column_count[0]) begin
        pair_sums <= '{PAIR_W'(red), PAIR_W'(green), PAIR_W'(blue)};
      end else begin
        pair_sums <= pair_next;
      end
    end
  end

  // line buffer: even rows write, odd rows read
  assign slot     = AW'(column_count >> 1);
  assign store_we = accept && column_count[0] && !row_count[0];
  assign store_re = accept && column_count[0] && row_count[0];

  rgb2yuv_ram #(
    .WIDTH ($bits(pair_sum_t)),
    .DEPTH (DEPTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (store_we),
    .waddr (slot),
    .wdata (pair_next),
    .re    (store_re),
    .raddr (slot),
    .rdata (above)
  );

  // stage register, aligned with line buffer read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_red       <= red;
      s1_green     <= green;
      s1_blue      <= blue;
      s1_chroma    <= column_count[0] && row_count[0];
      s1_frame_end <= col_last && row_last;
      s1_pair      <= pair_next;
    end
  end

  // word for the back part, with 2x2 block sums
  always_comb begin
    push_word.red       = s1_red;
    push_word.green     = s1_green;
    push_word.blue      = s1_blue;
    push_word.chroma    = s1_chroma;
    push_word.frame_end = s1_frame_end;
    push_word.sum_red   = BLOCK_W'(s1_pair.red)   + BLOCK_W'(above.red);
    push_word.sum_green = BLOCK_W'(s1_pair.green) + BLOCK_W'(above.green);
    push_word.sum_blue  = BLOCK_W'(s1_pair.blue)  + BLOCK_W'(above.blue);
  end

endmodule

`default_nettype wire

// ===== design/rgb2yuv_queue.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_queue
// Short register FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2yuv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rgb2yuv_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] pop_data,
  output logic                  not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    count;

  assign full      = count == NW'(DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/rgb2yuv_back.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_back
// Takes words from the queue, computes luma and chroma, and holds the
// result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2yuv_back (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           word_valid,
  input  wire rgb2yuv_pkg::pix_word_t         word,
  output logic                                pop,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [rgb2yuv_pkg::COMP_W-1:0]      luma,
  output logic                                chroma_valid,
  output logic [rgb2yuv_pkg::COMP_W-1:0]      chroma_blue,
  output logic [rgb2yuv_pkg::COMP_W-1:0]      chroma_red,
  output logic                                frame_end
);

  import rgb2yuv_pkg::*;

  localparam int LUMA_SUM_W = 2 * COMP_W;

  logic                           b1_valid;
  logic [COMP_W-1:0]              b1_luma;
  logic                           b1_chroma;
  logic                           b1_frame_end;
  logic signed [CHROMA_SUM_W-1:0] b1_u;
  logic signed [CHROMA_SUM_W-1:0] b1_v;

  logic [LUMA_SUM_W-1:0]          luma_sum;
  logic signed [CHROMA_SUM_W-1:0] r_ext;
  logic signed [CHROMA_SUM_W-1:0] g_ext;
  logic signed [CHROMA_SUM_W-1:0] b_ext;
  logic signed [CHROMA_SUM_W-1:0] u_sum;
  logic signed [CHROMA_SUM_W-1:0] v_sum;
  logic signed [CHROMA_SUM_W-1:0] u_shift;
  logic signed [CHROMA_SUM_W-1:0] v_shift;
  logic                           out_load;

  // stage advance
  assign out_load = b1_valid && (!out_valid || !out_stall);
  assign pop      = word_valid && (!b1_valid || out_load);

  // constant-coefficient products
  always_comb begin
    luma_sum = LUMA_SUM_W'(LUMA_COEF_R * word.red + LUMA_COEF_G * word.green
                           + LUMA_COEF_B * word.blue);
    r_ext = CHROMA_SUM_W'(word.sum_red);
    g_ext = CHROMA_SUM_W'(word.sum_green);
    b_ext = CHROMA_SUM_W'(word.sum_blue);
    u_sum = CHROMA_SUM_W'(CB_COEF_B * b_ext - CB_COEF_R * r_ext - CB_COEF_G * g_ext);
    v_sum = CHROMA_SUM_W'(CR_COEF_R * r_ext - CR_COEF_G * g_ext - CR_COEF_B * b_ext);
  end

  // first stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (pop) begin
      b1_valid <= 1'b1;
    end else if (out_load) begin
      b1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_luma      <= COMP_W'(luma_sum >> LUMA_SHIFT) + COMP_W'(LUMA_OFFSET);
      b1_chroma    <= word.chroma;
      b1_frame_end <= word.frame_end;
      b1_u         <= u_sum;
      b1_v         <= v_sum;
    end
  end

  // floor shift of the chroma sums
  assign u_shift = b1_u >>> CHROMA_SHIFT;
  assign v_shift = b1_v >>> CHROMA_SHIFT;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      luma         <= b1_luma;
      chroma_valid <= b1_chroma;
      frame_end    <= b1_frame_end;
      if (b1_chroma) begin
        chroma_blue <= COMP_W'(u_shift) + COMP_W'(CHROMA_OFFSET);
        chroma_red  <= COMP_W'(v_shift) + COMP_W'(CHROMA_OFFSET);
      end else begin
        chroma_blue <= '0;
        chroma_red  <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/rgb_to_yuv420_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_yuv420_converter
// BT.601 RGB to YCbCr 4:2:0 converter over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on red/green/blue with in_valid; a word is taken at a clock
//   edge with in_valid high and in_stall low. Each pixel gives one result
//   word on the output channel (out_valid / out_stall): luma always, and at
//   the odd-row, odd-column pixel of every 2x2 block chroma_valid with the
//   block's chroma_blue and chroma_red. frame_end marks the frame's last
//   pixel.
//   frame_width (index 0) and frame_height (index 1) are written over the
//   cfg port, which is always ready; write them only while the block is idle.
//   A pixel passes the front stage, the queue, the back stage and the output
//   register. One pixel per clock is sustained while out_stall is low, set by
//   the single line-buffer access and one luma/chroma multiplier pass per pixel.
//   Reset clears the position to the top-left pixel and the sizes to
//   640 x 480. The line buffer needs no clearing.
//   When the receiver stalls, the output word holds, the back part and the
//   4-entry queue fill, and in_stall rises once the front stage is blocked.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_yuv420_converter #(
  parameter int MAX_WIDTH  = rgb2yuv_pkg::MAX_WIDTH_DEFAULT,
  parameter int MAX_HEIGHT = rgb2yuv_pkg::MAX_HEIGHT_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [rgb2yuv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [rgb2yuv_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [rgb2yuv_pkg::COMP_W-1:0]      red,
  input  wire logic [rgb2yuv_pkg::COMP_W-1:0]      green,
  input  wire logic [rgb2yuv_pkg::COMP_W-1:0]      blue,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [rgb2yuv_pkg::COMP_W-1:0]           luma,
  output logic                                     chroma_valid,
  output logic [rgb2yuv_pkg::COMP_W-1:0]           chroma_blue,
  output logic [rgb2yuv_pkg::COMP_W-1:0]           chroma_red,
  output logic                                     frame_end
);

  import rgb2yuv_pkg::*;

  logic      push;
  logic      queue_full;
  logic      pop;
  logic      word_valid;
  pix_word_t push_word;
  pix_word_t pop_word;

  assign cfg_ready = 1'b1;

  // front: position, pair sums, line buffer
  rgb2yuv_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .push       (push),
    .push_word  (push_word),
    .queue_full (queue_full)
  );

  // decoupling queue
  rgb2yuv_queue #(
    .WIDTH ($bits(pix_word_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_word),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_word),
    .not_empty (word_valid)
  );

  // back: color math and output register
  rgb2yuv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .word_valid   (word_valid),
    .word         (pop_word),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .luma         (luma),
    .chroma_valid (chroma_valid),
    .chroma_blue  (chroma_blue),
    .chroma_red   (chroma_red),
    .frame_end    (frame_end)
  );

endmodule

`default_nettype wire

// ===== design/rgb2yuv_checker.sv =====
// ----------------------------------------------------------------------------
// rgb2yuv_checker
// Port-level checks on the converter's output channel, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb2yuv_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] luma,
  input wire logic       chroma_valid,
  input wire logic [7:0] chroma_blue,
  input wire logic [7:0] chroma_red
);

  // a stalled word stays offered
  a_valid_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("output word dropped while stalled");

  // luma stays in the video range
  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (luma >= 8'd16) && (luma <= 8'd235))
    else $error("luma out of range");

  // chroma is zero on words that close no block
  a_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !chroma_valid |-> (chroma_blue == 8'd0) && (chroma_red == 8'd0))
    else $error("chroma set without a completed block");

  // chroma stays in the video range
  a_chroma_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && chroma_valid |->
      (chroma_blue >= 8'd16) && (chroma_blue <= 8'd240) &&
      (chroma_red >= 8'd16) && (chroma_red <= 8'd240))
    else $error("chroma out of range");

endmodule

bind rgb_to_yuv420_converter rgb2yuv_checker u_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB to YCbCr 4:2:0 converter. Pixels are fed
// in raster order under several frame sizes, including odd, clamped and
// mid-frame size changes. A bit-exact copy of the conversion, with its own
// position counters, pair sums and line buffer, turns every accepted pixel
// into the result word it should produce. Output words are matched in order.
// Both channels idle and stall at random; every fourth phase holds the output
// off long enough to back the stream up to the input.
// ----------------------------------------------------------------------------

module tb_top;
  import rgb2yuv_pkg::*;

  localparam int STORE_DEPTH = MAX_WIDTH_DEFAULT / 2;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD   = 60;
  localparam int PHASE_COUNT = 10;
  localparam int PHASE_ITEMS = 60;
  localparam int TAIL_CYCLES = 8;
  localparam int REPORT_MAX  = 10;

  // index that maps to no register, the block must ignore writes to it
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  // one result word, in port order
  typedef struct packed {
    logic [COMP_W-1:0] luma;
    logic              chroma_valid;
    logic [COMP_W-1:0] chroma_blue;
    logic [COMP_W-1:0] chroma_red;
    logic              frame_end;
  } yuv_word_t;

  // conversion copy and in-order match of result words
  class yuv420_ledger;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    int unsigned           col;
    int unsigned           row;
    pair_sum_t             pair;
    pair_sum_t             line_buf [STORE_DEPTH];
    bit                    line_written [STORE_DEPTH];
    yuv_word_t             pending_yuv [$];
    int unsigned           mismatch_count;

    function new();
      width_reg      = FRAME_WIDTH_RESET;
      height_reg     = FRAME_HEIGHT_RESET;
      col            = 0;
      row            = 0;
      pair           = '0;
      mismatch_count = 0;
      foreach (line_buf[i]) line_buf[i] = '0;
    endfunction

    // even size, clamped to 2..limit
    function int unsigned clamp_size(logic [CFG_DATA_W-1:0] raw, int unsigned limit);
      int unsigned v;
      v = raw & ~32'd1;
      if (v < 2) v = 2;
      if (v > limit) v = limit;
      return v;
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) width_reg = val;
      else if (idx == REG_FRAME_HEIGHT) height_reg = val;
    endfunction

    // true when switching to this width now reads only filled line buffer slots
    function bit width_safe(logic [CFG_DATA_W-1:0] raw);
      int unsigned w, first, last, s;
      w = clamp_size(raw, MAX_WIDTH_DEFAULT);
      if (row % 2 == 0) return 1'b1;
      if (col % 2 == 0 && col >= w - 1) return 1'b1;
      first = col >> 1;
      last  = (w / 2 - 1 > first) ? w / 2 - 1 : first;
      for (s = first; s <= last; s++)
        if (!line_written[s % STORE_DEPTH]) return 1'b0;
      return 1'b1;
    endfunction

    // convert one accepted pixel and queue its result word
    function void take_pixel(logic [COMP_W-1:0] r, logic [COMP_W-1:0] g,
                             logic [COMP_W-1:0] b);
      yuv_word_t   word;
      int unsigned w, h, slot;
      pair_sum_t   above;
      int          sum_r, sum_g, sum_b, cb_sum, cr_sum;
      w    = clamp_size(width_reg, MAX_WIDTH_DEFAULT);
      h    = clamp_size(height_reg, MAX_HEIGHT_DEFAULT);
      word = '0;
      word.luma = 8'(((LUMA_COEF_R * r + LUMA_COEF_G * g + LUMA_COEF_B * b)
                      >> LUMA_SHIFT) + LUMA_OFFSET);
      slot = (col >> 1) % STORE_DEPTH;

      // horizontal pair, then the block with the row above
      if (col % 2 == 0) begin
        pair.red   = r;
        pair.green = g;
        pair.blue  = b;
      end else begin
        pair.red   = pair.red + r;
        pair.green = pair.green + g;
        pair.blue  = pair.blue + b;
        if (row % 2 == 0) begin
          line_buf[slot]     = pair;
          line_written[slot] = 1'b1;
        end else begin
          above  = line_buf[slot];
          sum_r  = int'(pair.red) + int'(above.red);
          sum_g  = int'(pair.green) + int'(above.green);
          sum_b  = int'(pair.blue) + int'(above.blue);
          cb_sum = -CB_COEF_R * sum_r - CB_COEF_G * sum_g + CB_COEF_B * sum_b;
          cr_sum = CR_COEF_R * sum_r - CR_COEF_G * sum_g - CR_COEF_B * sum_b;
          word.chroma_blue  = 8'((cb_sum >>> CHROMA_SHIFT) + CHROMA_OFFSET);
          word.chroma_red   = 8'((cr_sum >>> CHROMA_SHIFT) + CHROMA_OFFSET);
          word.chroma_valid = 1'b1;
        end
      end

      // raster position, tolerant of sizes shrinking mid-frame
      if (col >= w - 1) begin
        col = 0;
        if (row >= h - 1) begin
          row = 0;
          word.frame_end = 1'b1;
        end else begin
          row++;
        end
      end else begin
        col++;
      end
      pending_yuv.push_back(word);
    endfunction

    function void note_mismatch(string field, logic [COMP_W-1:0] want,
                                logic [COMP_W-1:0] got);
      if (mismatch_count < REPORT_MAX)
        $display("%0t: %s mismatch, expected %0h got %0h", $time, field, want, got);
      mismatch_count++;
    endfunction

    // match one output word against the oldest pending one
    function void match_yuv(yuv_word_t got);
      yuv_word_t want;
      if (pending_yuv.size() == 0) begin
        if (mismatch_count < REPORT_MAX)
          $display("%0t: output word with nothing pending, luma %0h", $time, got.luma);
        mismatch_count++;
        return;
      end
      want = pending_yuv.pop_front();
      if (got.luma !== want.luma) note_mismatch("luma", want.luma, got.luma);
      if (got.chroma_valid !== want.chroma_valid)
        note_mismatch("chroma_valid", want.chroma_valid, got.chroma_valid);
      if (got.chroma_blue !== want.chroma_blue)
        note_mismatch("chroma_blue", want.chroma_blue, got.chroma_blue);
      if (got.chroma_red !== want.chroma_red)
        note_mismatch("chroma_red", want.chroma_red, got.chroma_red);
      if (got.frame_end !== want.frame_end)
        note_mismatch("frame_end", want.frame_end, got.frame_end);
    endfunction
  endclass

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [COMP_W-1:0]      red       = '0;
  logic [COMP_W-1:0]      green     = '0;
  logic [COMP_W-1:0]      blue      = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [COMP_W-1:0]      luma;
  logic                   chroma_valid;
  logic [COMP_W-1:0]      chroma_blue;
  logic [COMP_W-1:0]      chroma_red;
  logic                   frame_end;

  yuv420_ledger yuv_book;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct     = 0;
  int unsigned  hold_token    = 0;
  int unsigned  hold_seen     = 0;
  int unsigned  hold_left     = 0;
  int unsigned  quiet_cycles  = 0;

  rgb_to_yuv420_converter u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .luma         (luma),
    .chroma_valid (chroma_valid),
    .chroma_blue  (chroma_blue),
    .chroma_red   (chroma_red),
    .frame_end    (frame_end)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // output side: take words, stall at random or for a long hold
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        yuv_book.match_yuv({luma, chroma_valid, chroma_blue, chroma_red, frame_end});
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rgb_to_yuv420_converter regression: fail");
      $finish;
    end
  end

  // component value biased toward the ends of the range
  function automatic logic [COMP_W-1:0] pick_level();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return COMP_W'($urandom_range(255));
    endcase
  endfunction

  // basic colors for the directed blocks
  function automatic logic [3*COMP_W-1:0] swatch(int idx);
    case (idx)
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      2:       return 24'hFF0000;
      3:       return 24'h00FF00;
      default: return 24'h0000FF;
    endcase
  endfunction

  // offer one pixel word, with random idle cycles ahead of it
  task automatic send_pixel(input logic [COMP_W-1:0] r, input logic [COMP_W-1:0] g,
                            input logic [COMP_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    red      <= r;
    green    <= g;
    blue     <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    yuv_book.take_pixel(r, g, b);
  endtask

  // stop sending and wait for every pending word
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (yuv_book.pending_yuv.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    yuv_book.set_register(idx, val);
  endtask

  // move to a row where the new width cannot read empty slots, idle, then write
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input bit poke_spare);
    while (!yuv_book.width_safe(w)) send_pixel(pick_level(), pick_level(), pick_level());
    drain();
    if (poke_spare) write_register(REG_SPARE, CFG_DATA_W'($urandom_range(4095)));
    write_register(REG_FRAME_WIDTH, w);
    write_register(REG_FRAME_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                    phase;
    int                    k;
    logic [CFG_DATA_W-1:0] w_raw;
    logic [CFG_DATA_W-1:0] h_raw;
    logic [3*COMP_W-1:0]   color;
    yuv_book = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // start a row at reset size, then shrink to 2x2 mid-row
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);
    reconfigure(12'd2, 12'd2, 1'b0);
    send_pixel('1, '1, '1);
    send_pixel('0, '0, '0);
    send_pixel('1, '1, '1);

    // one flat 2x2 block per basic color
    for (k = 0; k < 20; k++) begin
      color = swatch(k / 4);
      send_pixel(color[23:16], color[15:8], color[7:0]);
    end

    // random phases over frame sizes and idling patterns
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          w_raw = 12'd5;
          h_raw = 12'd3;
        end
        1: begin
          w_raw = 12'd0;
          h_raw = 12'd1;
        end
        2: begin
          w_raw = 12'd4095;
          h_raw = 12'd4095;
        end
        3: begin
          w_raw = 12'd2048;
          h_raw = 12'd2;
        end
        default: begin
          w_raw = CFG_DATA_W'(2 * $urandom_range(1, 12));
          h_raw = CFG_DATA_W'(2 * $urandom_range(1, 4));
          if ($urandom_range(3) == 0) w_raw[0] = 1'b1;
          if ($urandom_range(3) == 0) h_raw[0] = 1'b1;
        end
      endcase
      reconfigure(w_raw, h_raw, phase == 1);

      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 58;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 58;
        end
        default: begin
          send_idle_pct = 19;
          stall_pct     = 19;
        end
      endcase

      // long output hold while the input keeps offering words
      if (phase % 4 == 0) begin
        @(negedge clk);
        hold_token++;
        @(posedge clk);
      end

      for (k = 0; k < PHASE_ITEMS; k++)
        send_pixel(pick_level(), pick_level(), pick_level());
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (yuv_book.mismatch_count == 0 && yuv_book.pending_yuv.size() == 0) begin
      $display("rgb_to_yuv420_converter regression: pass");
    end else begin
      $display("rgb_to_yuv420_converter regression: fail");
    end
    $finish;
  end

endmodule

// ===== rgb_to_yuv420_converter.f =====
design/rgb2yuv_pkg.sv
design/rgb2yuv_ram.sv
design/rgb2yuv_front.sv
design/rgb2yuv_queue.sv
design/rgb2yuv_back.sv
design/rgb_to_yuv420_converter.sv
design/rgb2yuv_checker.sv
bench/tb_top.sv
